FILE: rtl/ugre_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the glyph row expander
package ugre_pkg;

    localparam int GLYPH_COUNT_DEF = 65536;
    localparam int GLYPH_BYTES     = 32;
    localparam int GLYPH_ROWS      = 16;
    localparam int QUEUE_DEPTH     = 2;

    // operation codes of an input word, reused for queued commands
    localparam logic OP_TEXT    = 1'b0;
    localparam logic OP_FONT_WR = 1'b1;

    // command passed from the decoder to the font fetch side
    typedef struct packed {
        logic        op;
        logic [15:0] code_point;
        logic [15:0] glyph_x;
        logic [20:0] font_address;
        logic [7:0]  font_byte;
    } t_cmd;

    // one fetched glyph, rows already aligned
    typedef struct packed {
        logic [15:0]                 code_point;
        logic [15:0]                 glyph_x;
        logic                        narrow;
        logic [GLYPH_ROWS-1:0][15:0] rows;
    } t_glyph;

endpackage

FILE: rtl/ugre_front.sv
`timescale 1ns / 1ps
// utf-8 decoder and cursor tracking, front of the expander
module ugre_front #(
    parameter int GLYPH_COUNT = ugre_pkg::GLYPH_COUNT_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  logic          i_op,
    input  logic [7:0]    i_text_byte,
    input  logic [20:0]   i_font_address,
    input  logic [7:0]    i_font_byte,
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic [15:0]   i_cfg_data,
    input  logic          i_q_full,
    output logic          o_q_push,
    output ugre_pkg::t_cmd o_q_cmd
);
    import ugre_pkg::*;

    localparam logic [16:0] GLYPH_LIM = 17'(GLYPH_COUNT);

    logic [15:0] r_start_x;
    logic [15:0] r_cursor_x;
    logic [15:0] r_partial;
    logic [1:0]  r_pend;
    logic [15:0] n_cursor_x;
    logic [15:0] n_partial;
    logic [1:0]  n_pend;
    logic        accept;
    logic        finish;
    logic        in_range;
    logic [15:0] cp;
    logic [5:0]  low6;

    assign o_in_stall  = i_q_full;
    assign o_cfg_ready = 1'b1;
    assign accept      = i_in_valid & ~i_q_full;
    assign low6        = i_text_byte[5:0];

    always_comb begin
        n_cursor_x = r_cursor_x;
        n_partial  = r_partial;
        n_pend     = r_pend;
        finish     = 1'b0;
        cp         = 16'h0000;
        if (accept && i_op == OP_TEXT) begin
            if (i_text_byte == 8'h00) begin
                n_partial  = 16'h0000;
                n_pend     = 2'd0;
                n_cursor_x = r_start_x;
            end else if (r_pend == 2'd2) begin
                n_partial = r_partial | {4'h0, low6, 6'h00};
                n_pend    = 2'd1;
            end else if (r_pend == 2'd1) begin
                cp        = r_partial | {10'h000, low6};
                n_partial = 16'h0000;
                n_pend    = 2'd0;
                finish    = 1'b1;
            end else begin
                n_pend = 2'd0;
                if (!i_text_byte[7]) begin
                    cp     = {8'h00, i_text_byte};
                    finish = 1'b1;
                end else if (i_text_byte < 8'hE0) begin
                    // stray continuation bytes land here as two-byte leads
                    n_partial = {5'h00, i_text_byte[4:0], 6'h00};
                    n_pend    = 2'd1;
                end else if (i_text_byte < 8'hF0) begin
                    n_partial = {i_text_byte[3:0], 12'h000};
                    n_pend    = 2'd2;
                end else begin
                    // four-byte lead consumed alone as code point zero
                    n_partial = 16'h0000;
                    finish    = 1'b1;
                end
            end
            if (finish) begin
                n_cursor_x = r_cursor_x + ((cp < 16'd128) ? 16'd8 : 16'd16);
            end
        end
    end

    assign in_range = {1'b0, cp} < GLYPH_LIM;
    assign o_q_push = accept & ((i_op == OP_FONT_WR) | (finish & in_range));

    always_comb begin
        o_q_cmd.op           = i_op;
        o_q_cmd.code_point   = cp;
        o_q_cmd.glyph_x      = r_cursor_x;
        o_q_cmd.font_address = i_font_address;
        o_q_cmd.font_byte    = i_font_byte;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_x  <= 16'h0000;
            r_cursor_x <= 16'h0000;
            r_partial  <= 16'h0000;
            r_pend     <= 2'd0;
        end else begin
            if (i_cfg_valid) begin
                r_start_x <= i_cfg_data;
            end
            r_cursor_x <= n_cursor_x;
            r_partial  <= n_partial;
            r_pend     <= n_pend;
        end
    end

endmodule

FILE: rtl/ugre_queue.sv
`timescale 1ns / 1ps
// short command queue between decoder and font fetch
module ugre_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  ugre_pkg::t_cmd i_cmd,
    output logic           o_full,
    output logic           o_valid,
    output ugre_pkg::t_cmd o_cmd,
    input  logic           i_pop
);
    import ugre_pkg::*;

    localparam int QD = QUEUE_DEPTH;
    localparam int PW = (QD > 1) ? $clog2(QD) : 1;
    localparam int CW = $clog2(QD + 1);

    t_cmd            r_mem [QD];
    logic [PW-1:0]   r_wr_ptr;
    logic [PW-1:0]   r_rd_ptr;
    logic [CW-1:0]   r_count;
    logic            do_push;
    logic            do_pop;

    assign o_full  = r_count == CW'(QD);
    assign o_valid = r_count != '0;
    assign o_cmd   = r_mem[r_rd_ptr];
    assign do_push = i_push & ~o_full;
    assign do_pop  = i_pop & o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(QD - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(QD - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

FILE: rtl/ugre_fetch.sv
`timescale 1ns / 1ps
// font store and glyph byte fetch sequencer
module ugre_fetch #(
    parameter int GLYPH_COUNT = ugre_pkg::GLYPH_COUNT_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_valid,
    input  ugre_pkg::t_cmd   i_q_cmd,
    output logic             o_q_pop,
    output logic             o_glyph_valid,
    output ugre_pkg::t_glyph o_glyph,
    input  logic             i_glyph_take
);
    import ugre_pkg::*;

    localparam int FONT_DEPTH = GLYPH_COUNT * GLYPH_BYTES;
    localparam int AW         = $clog2(FONT_DEPTH);
    localparam int CPW        = $clog2(GLYPH_COUNT);
    localparam int BW         = $clog2(GLYPH_BYTES);
    localparam logic [21:0] DEPTH_LIM = 22'(FONT_DEPTH);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_READ  = 4'b0010,
        S_DRAIN = 4'b0100,
        S_HAND  = 4'b1000
    } t_state;

    logic [7:0]    r_font [FONT_DEPTH];
    logic [7:0]    r_rd_data;
    logic          r_cap_vld;
    logic [BW-1:0] r_cap_idx;
    logic [7:0]    r_buf [GLYPH_BYTES];
    logic [BW-1:0] r_cnt;
    logic [15:0]   r_cp;
    logic [15:0]   r_x;
    t_state        r_state;
    t_state        n_state;
    logic          wr_en;
    logic          rd_en;
    logic          start;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;
    logic          narrow;

    assign o_q_pop = (r_state == S_IDLE) & i_q_valid;
    assign start   = o_q_pop & (i_q_cmd.op == OP_TEXT);
    assign wr_en   = o_q_pop & (i_q_cmd.op == OP_FONT_WR)
                   & ({1'b0, i_q_cmd.font_address} < DEPTH_LIM);
    assign wr_addr = i_q_cmd.font_address[AW-1:0];
    assign rd_en   = r_state == S_READ;
    assign rd_addr = {r_cp[CPW-1:0], r_cnt};

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_font[wr_addr] <= i_q_cmd.font_byte;
        end
        if (rd_en) begin
            r_rd_data <= r_font[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        r_cap_idx <= r_cnt;
        if (r_cap_vld) begin
            r_buf[r_cap_idx] <= r_rd_data;
        end
        if (start) begin
            r_cp <= i_q_cmd.code_point;
            r_x  <= i_q_cmd.glyph_x;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (start) n_state = S_READ;
            end
            S_READ: begin
                if (r_cnt == BW'(GLYPH_BYTES - 1)) n_state = S_DRAIN;
            end
            S_DRAIN: begin
                n_state = S_HAND;
            end
            S_HAND: begin
                if (i_glyph_take) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cnt     <= '0;
            r_cap_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cap_vld <= rd_en;
            if (start) begin
                r_cnt <= '0;
            end else if (rd_en) begin
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    // narrow when the last sixteen bytes (16 to 31) of the glyph are all zero
    always_comb begin
        narrow = 1'b1;
        for (int i = GLYPH_ROWS; i < GLYPH_BYTES; i++) begin
            if (r_buf[i] != 8'h00) narrow = 1'b0;
        end
    end

    always_comb begin
        o_glyph.code_point = r_cp;
        o_glyph.glyph_x    = r_x;
        o_glyph.narrow     = narrow;
        for (int r = 0; r < GLYPH_ROWS; r++) begin
            o_glyph.rows[r] = narrow ? {r_buf[r], 8'h00} : {r_buf[2*r], r_buf[2*r+1]};
        end
    end

    assign o_glyph_valid = r_state == S_HAND;

endmodule

FILE: rtl/ugre_emit.sv
`timescale 1ns / 1ps
// glyph row emitter with output hold under stall
module ugre_emit (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_glyph_valid,
    input  ugre_pkg::t_glyph i_glyph,
    output logic             o_glyph_take,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output logic [15:0]      o_code_point,
    output logic [15:0]      o_glyph_x,
    output logic [3:0]       o_row_index,
    output logic [15:0]      o_row_bits,
    output logic             o_narrow,
    output logic             o_last_row
);
    import ugre_pkg::*;

    t_glyph      r_glyph;
    logic        r_busy;
    logic [3:0]  r_row;
    logic        out_acc;
    logic        last;

    assign out_acc      = r_busy & ~i_out_stall;
    assign last         = r_row == 4'(GLYPH_ROWS - 1);
    assign o_glyph_take = i_glyph_valid & (~r_busy | (out_acc & last));

    always_ff @(posedge i_clk) begin
        if (o_glyph_take) begin
            r_glyph <= i_glyph;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_row  <= 4'h0;
        end else if (o_glyph_take) begin
            r_busy <= 1'b1;
            r_row  <= 4'h0;
        end else if (out_acc) begin
            if (last) begin
                r_busy <= 1'b0;
            end else begin
                r_row <= r_row + 1'b1;
            end
        end
    end

    assign o_out_valid  = r_busy;
    assign o_code_point = r_glyph.code_point;
    assign o_glyph_x    = r_glyph.glyph_x;
    assign o_row_index  = r_row;
    assign o_row_bits   = r_glyph.rows[r_row];
    assign o_narrow     = r_glyph.narrow;
    assign o_last_row   = last;

endmodule

FILE: rtl/utf8_text_glyph_row_expander_unit.sv
`timescale 1ns / 1ps
// top level of the utf-8 text to glyph row expander
//
// input channel (i_in_valid / o_in_stall): one word per accepted edge, either a
//   text byte (i_op low) or a font store byte write (i_op high)
// output channel (o_out_valid / i_out_stall): one glyph row per word, 16 words
//   per glyph, o_last_row marks row 15
// config channel (i_cfg_valid / o_cfg_ready): writes start_x, always ready;
//   write it only while the block is idle
// the decoder takes one input word per cycle until the two-entry command
//   queue is full; two- and three-byte leads and zero bytes never enter the queue
// in the fetch side a glyph takes a pop, 32 byte reads from the single read
//   port of the byte-wide font memory, a drain and a hand-off; this memory
//   port sets the sustained glyph rate, and no new command is popped until hand-off
// a font write is popped and written from the idle state without leaving it
// with queue and fetch side empty, the first row follows the queue, the reads,
//   drain and hand-off; then one row per cycle while not stalled
// the row emitter holds its word while stalled and takes the next glyph in the
//   same cycle its last row leaves, so fetch of the next glyph overlaps output
// reset clears decoder state, cursor, start_x, queue and sequencers; the font
//   memory is not cleared and must be written before a glyph is read
module utf8_text_glyph_row_expander_unit #(
    parameter int GLYPH_COUNT = ugre_pkg::GLYPH_COUNT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_op,
    input  logic [7:0]  i_text_byte,
    input  logic [20:0] i_font_address,
    input  logic [7:0]  i_font_byte,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [15:0] o_code_point,
    output logic [15:0] o_glyph_x,
    output logic [3:0]  o_row_index,
    output logic [15:0] o_row_bits,
    output logic        o_narrow,
    output logic        o_last_row
);
    import ugre_pkg::*;

    // decoder to queue
    logic   q_push;
    logic   q_full;
    t_cmd   q_in_cmd;
    // queue to fetch
    logic   q_valid;
    logic   q_pop;
    t_cmd   q_out_cmd;
    // fetch to emitter
    logic   glyph_valid;
    logic   glyph_take;
    t_glyph glyph;

    // front: utf-8 decode, cursor and start_x
    ugre_front #(
        .GLYPH_COUNT (GLYPH_COUNT)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_op           (i_op),
        .i_text_byte    (i_text_byte),
        .i_font_address (i_font_address),
        .i_font_byte    (i_font_byte),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data),
        .i_q_full       (q_full),
        .o_q_push       (q_push),
        .o_q_cmd        (q_in_cmd)
    );

    // command queue keeps font writes in order with glyph reads
    ugre_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_in_cmd),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_cmd   (q_out_cmd),
        .i_pop   (q_pop)
    );

    // back: font memory and byte fetch
    ugre_fetch #(
        .GLYPH_COUNT (GLYPH_COUNT)
    ) u_fetch (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (q_valid),
        .i_q_cmd       (q_out_cmd),
        .o_q_pop       (q_pop),
        .o_glyph_valid (glyph_valid),
        .o_glyph       (glyph),
        .i_glyph_take  (glyph_take)
    );

    // back: row output
    ugre_emit u_emit (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_glyph_valid (glyph_valid),
        .i_glyph       (glyph),
        .o_glyph_take  (glyph_take),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_code_point  (o_code_point),
        .o_glyph_x     (o_glyph_x),
        .o_row_index   (o_row_index),
        .o_row_bits    (o_row_bits),
        .o_narrow      (o_narrow),
        .o_last_row    (o_last_row)
    );

endmodule
